@@ rtl/lrb_pkg.sv @@
// shared widths and types for the bresenham line rasterizer
package lrb_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 32;
  localparam int WIDTH_BITS = 13;
  localparam int ADDR_BITS  = 24;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int MUL_BITS   = COORD_BITS + WIDTH_BITS;
  localparam int SUM_BITS   = (MUL_BITS > ADDR_BITS) ? MUL_BITS : ADDR_BITS;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(320);

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic [COLOR_BITS-1:0]      color_t;
  typedef logic [WIDTH_BITS-1:0]      width_t;
  typedef logic [ADDR_BITS-1:0]       addr_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

endpackage

@@ rtl/lrb_in_if.sv @@
// command channel: start or step items
interface lrb_in_if;
  logic            valid;
  logic            ready;
  logic            kind;
  lrb_pkg::coord_t start_x;
  lrb_pkg::coord_t start_y;
  lrb_pkg::coord_t end_x;
  lrb_pkg::coord_t end_y;
  lrb_pkg::color_t pen_color;

  modport source (output valid, kind, start_x, start_y, end_x, end_y, pen_color,
                  input ready);
  modport sink   (input valid, kind, start_x, start_y, end_x, end_y, pen_color,
                  output ready);
endinterface

@@ rtl/lrb_out_if.sv @@
// pixel channel: one pixel write per item
interface lrb_out_if;
  logic            valid;
  logic            ready;
  lrb_pkg::addr_t  pixel_address;
  lrb_pkg::color_t pixel_value;
  logic            last_pixel;

  modport source (output valid, pixel_address, pixel_value, last_pixel, input ready);
  modport sink   (input valid, pixel_address, pixel_value, last_pixel, output ready);
endinterface

@@ rtl/line_rasterizer_bresenham_unit.sv @@
// bresenham line stepper top level
//
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    kind, start_x, start_y, end_x, end_y, pen_color
//  out_ch    out  valid/ready    pixel_address, pixel_value, last_pixel
//  cfg_*     in   cfg_wr_en      cfg_wr_data = line_width
//
// an item lands in the input register, then the step logic and the row*width
// multiply load the pixel register. one item per cycle is sustained while out_ch
// is ready; the limit is the single step/multiply stage.
// a step item while no line is active leaves without a pixel and without stalling.
// reset (rst_n low, synchronous) empties both registers, goes idle, width = 320.
// a pixel item waits in the input register while the pixel reg is full, untaken.
module line_rasterizer_bresenham_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  lrb_in_if.sink                              in_ch,
  lrb_out_if.source                           out_ch,
  input  logic                                cfg_wr_en,
  input  logic [lrb_pkg::WIDTH_BITS-1:0]      cfg_wr_data
);

  // input register
  logic            s1_valid_r;
  logic            s1_kind_r;
  lrb_pkg::coord_t s1_x1_r, s1_y1_r, s1_x2_r, s1_y2_r;
  lrb_pkg::color_t s1_color_r;

  // line state
  lrb_pkg::width_t width_r;
  lrb_pkg::coord_t cur_col_r, cur_row_r, goal_col_r, goal_row_r;
  lrb_pkg::coord_t delta_col_r, delta_row_r;
  logic            col_back_r, row_back_r;
  lrb_pkg::err_t   err_r;
  lrb_pkg::color_t color_r;
  logic            busy_r;

  // pixel register
  logic            out_valid_r;
  lrb_pkg::addr_t  out_addr_r;
  lrb_pkg::color_t out_value_r;
  logic            out_last_r;

  logic            drop;
  logic            s1_adv;
  logic            emit;

  lrb_pkg::coord_t cur_col_nxt, cur_row_nxt, goal_col_nxt, goal_row_nxt;
  lrb_pkg::coord_t delta_col_nxt, delta_row_nxt;
  logic            col_back_nxt, row_back_nxt;
  lrb_pkg::err_t   err_nxt;
  lrb_pkg::color_t color_nxt;
  logic            last_nxt;

  lrb_pkg::err_t   dx_ext, dy_ext, sdx_ext, sdy_ext;
  logic            col_step, row_step;

  logic [lrb_pkg::SUM_BITS-1:0] addr_sum;

  assign drop   = (s1_kind_r == lrb_pkg::KIND_TICK) && !busy_r;
  assign s1_adv = s1_valid_r && (drop || !out_valid_r || out_ch.ready);
  assign emit   = s1_adv && !drop;

  assign in_ch.ready = !s1_valid_r || s1_adv;

  // deltas from the stored line, or from the new endpoints on a start
  assign dx_ext  = lrb_pkg::err_t'({2'b00, delta_col_r});
  assign dy_ext  = lrb_pkg::err_t'({2'b00, delta_row_r});
  assign sdx_ext = lrb_pkg::err_t'({2'b00, delta_col_nxt});
  assign sdy_ext = lrb_pkg::err_t'({2'b00, delta_row_nxt});

  assign col_step = err_r > -dx_ext;
  assign row_step = err_r < dy_ext;

  always_comb begin
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    goal_col_nxt  = goal_col_r;
    goal_row_nxt  = goal_row_r;
    delta_col_nxt = delta_col_r;
    delta_row_nxt = delta_row_r;
    col_back_nxt  = col_back_r;
    row_back_nxt  = row_back_r;
    err_nxt       = err_r;
    color_nxt     = color_r;
    if (s1_kind_r == lrb_pkg::KIND_START) begin
      delta_col_nxt = (s1_x2_r >= s1_x1_r) ? s1_x2_r - s1_x1_r : s1_x1_r - s1_x2_r;
      delta_row_nxt = (s1_y2_r >= s1_y1_r) ? s1_y2_r - s1_y1_r : s1_y1_r - s1_y2_r;
      col_back_nxt  = !(s1_x1_r < s1_x2_r);
      row_back_nxt  = !(s1_y1_r < s1_y2_r);
      cur_col_nxt   = s1_x1_r;
      cur_row_nxt   = s1_y1_r;
      goal_col_nxt  = s1_x2_r;
      goal_row_nxt  = s1_y2_r;
      color_nxt     = s1_color_r;
      // halve toward zero: shift the magnitude, then negate for the row case
      if (delta_col_nxt > delta_row_nxt) begin
        err_nxt = sdx_ext >>> 1;
      end else begin
        err_nxt = -(sdy_ext >>> 1);
      end
    end else begin
      if (col_step) begin
        cur_col_nxt = col_back_r ? cur_col_r - 1'b1 : cur_col_r + 1'b1;
      end
      if (row_step) begin
        cur_row_nxt = row_back_r ? cur_row_r - 1'b1 : cur_row_r + 1'b1;
      end
      err_nxt = err_r - (col_step ? dy_ext : '0) + (row_step ? dx_ext : '0);
    end
  end

  assign last_nxt = (cur_col_nxt == goal_col_nxt) && (cur_row_nxt == goal_row_nxt);

  assign addr_sum = lrb_pkg::SUM_BITS'(cur_row_nxt) * lrb_pkg::SUM_BITS'(width_r)
                  + lrb_pkg::SUM_BITS'(cur_col_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      width_r     <= lrb_pkg::WIDTH_RESET;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      goal_col_r  <= '0;
      goal_row_r  <= '0;
      delta_col_r <= '0;
      delta_row_r <= '0;
      col_back_r  <= 1'b0;
      row_back_r  <= 1'b0;
      err_r       <= '0;
      color_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        width_r <= cfg_wr_data;
      end
      if (in_ch.valid && in_ch.ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (emit) begin
        cur_col_r   <= cur_col_nxt;
        cur_row_r   <= cur_row_nxt;
        goal_col_r  <= goal_col_nxt;
        goal_row_r  <= goal_row_nxt;
        delta_col_r <= delta_col_nxt;
        delta_row_r <= delta_row_nxt;
        col_back_r  <= col_back_nxt;
        row_back_r  <= row_back_nxt;
        err_r       <= err_nxt;
        color_r     <= color_nxt;
        busy_r      <= !last_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_kind_r  <= in_ch.kind;
      s1_x1_r    <= in_ch.start_x;
      s1_y1_r    <= in_ch.start_y;
      s1_x2_r    <= in_ch.end_x;
      s1_y2_r    <= in_ch.end_y;
      s1_color_r <= in_ch.pen_color;
    end
    if (emit) begin
      out_addr_r  <= addr_sum[lrb_pkg::ADDR_BITS-1:0];
      out_value_r <= color_nxt;
      out_last_r  <= last_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_address = out_addr_r;
  assign out_ch.pixel_value   = out_value_r;
  assign out_ch.last_pixel    = out_last_r;

endmodule
